### rtl/core/twodo_pkg.sv
// Shared constants and the CORDIC angle table for the tracking wheel odometry block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package twodo_pkg;

  // Field and port widths.
  localparam int POS_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TILES     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HDG = 2'd3;

  localparam logic [POS_W-1:0]        TILES_RESET     = 32'd96505476;
  localparam logic signed [POS_W-1:0] START_X_RESET   = 32'sd0;
  localparam logic signed [POS_W-1:0] START_Y_RESET   = 32'sd0;
  localparam logic signed [POS_W-1:0] START_HDG_RESET = 32'sd0;

  // CORDIC iteration count, capped by the length of the angle table.
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 30;
  localparam int ATAN_IDX_W   = 5;
  localparam int ATAN_W       = 23;
  localparam int ROT_STEPS    = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int MOD_STEPS    = 8;
  localparam int MOD_K_W      = 3;
  localparam int CNT_W        = (ROT_STEPS > MOD_STEPS) ? $clog2(ROT_STEPS) : MOD_K_W;

  // Datapath widths.
  localparam int DELTA_W = POS_W + 1;   // wheel delta
  localparam int VEC_W   = 44;          // rotated vector, Q.24
  localparam int ANG_W   = 28;          // folded angle, 2^-17 degree
  localparam int MOD_W   = 34;          // angle during the modulo reduction
  localparam int FOLD_W  = 26;          // reduced angle, below one full turn
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 33;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int LOW_W   = 16;          // low part of the split scale multiply
  localparam int HIGH_W  = VEC_W - LOW_W;
  localparam int ACC_W   = 60;
  localparam int SSUM_W  = ACC_W + 1;
  localparam int SCALE_SHIFT = 20;
  localparam int RSH_W   = SSUM_W - SCALE_SHIFT;
  localparam int INC_W   = RSH_W + 1;
  localparam int SUM_W   = INC_W + 1;

  localparam int GAIN_Q30   = 652032874;
  localparam int GAIN_SHIFT = 22;
  localparam int ROUND_HALF = 2 ** (SCALE_SHIFT - 1);

  localparam int FULL_TURN    = 360 * 131072;
  localparam int HALF_TURN    = FULL_TURN / 2;
  localparam int QUARTER_TURN = FULL_TURN / 4;

  localparam logic [MOD_W-1:0] MOD_OFFSET =
    MOD_W'(64'(FULL_TURN) << (MOD_STEPS - 1));
  localparam logic signed [ANG_W-1:0] Z_FULL    = ANG_W'(FULL_TURN);
  localparam logic signed [ANG_W-1:0] Z_HALF    = ANG_W'(HALF_TURN);
  localparam logic signed [ANG_W-1:0] Z_QUARTER = ANG_W'(QUARTER_TURN);

  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-64'sd2147483648);

  // atan(2^-i) in units of 2^-17 degree.
  function automatic logic [ATAN_W-1:0] atan_deg17(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 23'd5898240;
      5'd1:    v = 23'd3481934;
      5'd2:    v = 23'd1839759;
      5'd3:    v = 23'd933890;
      5'd4:    v = 23'd468757;
      5'd5:    v = 23'd234607;
      5'd6:    v = 23'd117332;
      5'd7:    v = 23'd58670;
      5'd8:    v = 23'd29335;
      5'd9:    v = 23'd14668;
      5'd10:   v = 23'd7334;
      5'd11:   v = 23'd3667;
      5'd12:   v = 23'd1833;
      5'd13:   v = 23'd917;
      5'd14:   v = 23'd458;
      5'd15:   v = 23'd229;
      5'd16:   v = 23'd115;
      5'd17:   v = 23'd57;
      5'd18:   v = 23'd29;
      5'd19:   v = 23'd14;
      5'd20:   v = 23'd7;
      5'd21:   v = 23'd4;
      5'd22:   v = 23'd2;
      5'd23:   v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/core/twodo_if.sv
// Valid/ready stream interfaces for the odometry sample input and the pose result.
// Depends on twodo_pkg for the field widths.
`default_nettype none

interface twodo_in_if import twodo_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] forward_wheel_pos;
  logic signed [POS_W-1:0] side_wheel_pos;
  logic signed [POS_W-1:0] sensor_heading;

  modport source (output valid, output forward_wheel_pos, output side_wheel_pos,
                  output sensor_heading, input ready);
  modport sink (input valid, input forward_wheel_pos, input side_wheel_pos,
                input sensor_heading, output ready);
endinterface

interface twodo_out_if import twodo_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pose_x;
  logic signed [POS_W-1:0] pose_y;
  logic signed [POS_W-1:0] pose_heading;
  logic                    overflowed;

  modport source (output valid, output pose_x, output pose_y, output pose_heading,
                  output overflowed, input ready);
  modport sink (input valid, input pose_x, input pose_y, input pose_heading,
                input overflowed, output ready);
endinterface

`default_nettype wire

### rtl/core/tracking_wheel_odometry.sv
// Top level of the tracking wheel odometry block: sequencer, shared multiplier and CORDIC stage.
// Depends on twodo_pkg and the stream interfaces in twodo_if.sv.
`default_nettype none

// Tracks a Q16.16 pose from tracking wheel positions and an inertial heading. The first
// sample after reset only primes the stored wheel and heading values and returns the
// current pose. Every later sample rotates the wheel deltas by the midpoint heading with a
// CORDIC in degrees, scales them by tiles_per_rev and adds them to a saturating x/y pose;
// overflowed flags a saturated update. One sample is worked on at a time: a primed sample
// occupies the block from the accepting beat until it is back to ready, its work spread over
// the 8-step angle reduction, the one CORDIC shift-add stage and the one shared multiplier
// (two gain products, four scale products). A priming sample goes straight from the
// accepting beat to the done state. A finished result waits in the output register, so the
// next sample can be taken while it is unclaimed. Configuration writes belong to idle time;
// a start register write reloads that pose component at once.
module tracking_wheel_odometry import twodo_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  twodo_in_if.sink              in_ch,
  twodo_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_GAIN_F = 4'd1;
  localparam logic [3:0] S_GAIN_S = 4'd2;
  localparam logic [3:0] S_MOD    = 4'd3;
  localparam logic [3:0] S_FOLD   = 4'd4;
  localparam logic [3:0] S_ROT    = 4'd5;
  localparam logic [3:0] S_SCALE  = 4'd6;
  localparam logic [3:0] S_SUM    = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0]                state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      primed_r, primed_nxt;
  logic signed [POS_W-1:0]   prev_f_r, prev_f_nxt;
  logic signed [POS_W-1:0]   prev_s_r, prev_s_nxt;
  logic signed [POS_W-1:0]   prev_h_r, prev_h_nxt;
  logic [POS_W-1:0]          tiles_r, tiles_nxt;
  logic signed [POS_W-1:0]   pos_x_r, pos_x_nxt;
  logic signed [POS_W-1:0]   pos_y_r, pos_y_nxt;
  logic signed [POS_W-1:0]   head_r, head_nxt;
  logic                      ovf_r, ovf_nxt;
  logic signed [DELTA_W-1:0] d_f_r, d_f_nxt;
  logic signed [DELTA_W-1:0] d_s_r, d_s_nxt;
  logic [MOD_W-1:0]          zacc_r, zacc_nxt;
  logic signed [ANG_W-1:0]   z_r, z_nxt;
  logic signed [VEC_W-1:0]   cx_r, cx_nxt;
  logic signed [VEC_W-1:0]   cy_r, cy_nxt;
  logic [ACC_W-1:0]          acc_r, acc_nxt;
  logic signed [INC_W-1:0]   inc_x_r, inc_x_nxt;
  logic signed [INC_W-1:0]   inc_y_r, inc_y_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [POS_W-1:0]   out_x_r, out_x_nxt;
  logic signed [POS_W-1:0]   out_y_r, out_y_nxt;
  logic signed [POS_W-1:0]   out_h_r, out_h_nxt;
  logic                      out_ovf_r, out_ovf_nxt;

  logic                      in_acc;
  logic [MUL_A_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [VEC_W-1:0]   sel_v;
  logic [VEC_W-1:0]          mag;
  logic [SSUM_W-1:0]         ssum;
  logic [RSH_W-1:0]          rsh;
  logic signed [INC_W-1:0]   inc;
  logic signed [VEC_W-1:0]   sx;
  logic signed [VEC_W-1:0]   sy;
  logic signed [ANG_W-1:0]   atan_v;
  logic [MOD_K_W-1:0]        mod_k;
  logic [MOD_W-1:0]          mod_sub;
  logic signed [ANG_W-1:0]   zc;
  logic signed [DELTA_W-1:0] zsum;
  logic signed [SUM_W-1:0]   sum_x;
  logic signed [SUM_W-1:0]   sum_y;

  assign in_ch.ready         = (state_r == S_IDLE);
  assign in_acc              = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.pose_x       = out_x_r;
  assign out_ch.pose_y       = out_y_r;
  assign out_ch.pose_heading = out_h_r;
  assign out_ch.overflowed   = out_ovf_r;

  // Shared multiplier: wheel delta times the CORDIC gain compensation, or one half of the
  // split magnitude times tiles_per_rev (high part first, then low part).
  assign sel_v = cnt_r[1] ? cx_r : cy_r;
  assign mag   = sel_v[VEC_W-1] ? VEC_W'(-sel_v) : VEC_W'(sel_v);

  always_comb begin
    mul_a = '0;
    mul_b = MUL_B_W'({1'b0, tiles_r});
    case (state_r)
      S_GAIN_F: begin
        mul_a = MUL_A_W'(d_f_r);
        mul_b = MUL_B_W'(GAIN_Q30);
      end
      S_GAIN_S: begin
        mul_a = MUL_A_W'(d_s_r);
        mul_b = MUL_B_W'(GAIN_Q30);
      end
      S_SCALE: begin
        if (cnt_r[0]) begin
          mul_a = MUL_A_W'(mag[LOW_W-1:0]);
        end else begin
          mul_a = MUL_A_W'(mag[VEC_W-1:LOW_W]);
        end
      end
      default: mul_a = '0;
    endcase
  end

  assign prod = $signed(mul_a) * $signed(mul_b);

  // Rounded increment from the stored high product and the current low product.
  assign ssum = SSUM_W'(acc_r) + SSUM_W'(ROUND_HALF) + SSUM_W'(prod[LOW_W+POS_W-1:LOW_W]);
  assign rsh  = ssum[SSUM_W-1:SCALE_SHIFT];
  assign inc  = sel_v[VEC_W-1] ? -$signed({1'b0, rsh}) : $signed({1'b0, rsh});

  // CORDIC stage and the angle reduction step.
  assign sx      = cx_r >>> cnt_r;
  assign sy      = cy_r >>> cnt_r;
  assign atan_v  = $signed(ANG_W'(atan_deg17(ATAN_IDX_W'(cnt_r))));
  assign mod_k   = MOD_K_W'(MOD_STEPS - 1) - cnt_r[MOD_K_W-1:0];
  assign mod_sub = MOD_W'(FULL_TURN) << mod_k;
  assign zsum    = $signed({prev_h_r[POS_W-1], prev_h_r})
                 + $signed({in_ch.sensor_heading[POS_W-1], in_ch.sensor_heading});

  assign sum_x = SUM_W'(pos_x_r) + SUM_W'(inc_x_r);
  assign sum_y = SUM_W'(pos_y_r) + SUM_W'(inc_y_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    primed_nxt    = primed_r;
    prev_f_nxt    = prev_f_r;
    prev_s_nxt    = prev_s_r;
    prev_h_nxt    = prev_h_r;
    tiles_nxt     = tiles_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    head_nxt      = head_r;
    ovf_nxt       = ovf_r;
    d_f_nxt       = d_f_r;
    d_s_nxt       = d_s_r;
    zacc_nxt      = zacc_r;
    z_nxt         = z_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    acc_nxt       = acc_r;
    inc_x_nxt     = inc_x_r;
    inc_y_nxt     = inc_y_r;
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_h_nxt     = out_h_r;
    out_ovf_nxt   = out_ovf_r;
    zc            = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          d_f_nxt = $signed({in_ch.forward_wheel_pos[POS_W-1], in_ch.forward_wheel_pos})
                  - $signed({prev_f_r[POS_W-1], prev_f_r});
          d_s_nxt = $signed({in_ch.side_wheel_pos[POS_W-1], in_ch.side_wheel_pos})
                  - $signed({prev_s_r[POS_W-1], prev_s_r});
          // A whole number of turns is added so that the reduction works on a positive value.
          zacc_nxt   = MOD_W'(zsum) + MOD_OFFSET;
          prev_f_nxt = in_ch.forward_wheel_pos;
          prev_s_nxt = in_ch.side_wheel_pos;
          prev_h_nxt = in_ch.sensor_heading;
          primed_nxt = 1'b1;
          ovf_nxt    = 1'b0;
          cnt_nxt    = '0;
          state_nxt  = primed_r ? S_GAIN_F : S_DONE;
        end
      end
      S_GAIN_F: begin
        cx_nxt    = VEC_W'(prod >>> GAIN_SHIFT);
        state_nxt = S_GAIN_S;
      end
      S_GAIN_S: begin
        cy_nxt    = VEC_W'(prod >>> GAIN_SHIFT);
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (zacc_r >= mod_sub) begin
          zacc_nxt = zacc_r - mod_sub;
        end
        cnt_nxt = CNT_W'(cnt_r + 1'b1);
        if (cnt_r == CNT_W'(MOD_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        // Center the angle on zero, then fold the outer half-plane in by a half turn.
        zc = $signed(ANG_W'(zacc_r[FOLD_W-1:0]));
        if (zc >= Z_HALF) begin
          zc = zc - Z_FULL;
        end
        z_nxt = zc;
        if (zc > Z_QUARTER) begin
          cx_nxt = -cx_r;
          cy_nxt = -cy_r;
          z_nxt  = zc - Z_HALF;
        end else if (zc < -Z_QUARTER) begin
          cx_nxt = -cx_r;
          cy_nxt = -cy_r;
          z_nxt  = zc + Z_HALF;
        end
        state_nxt = S_ROT;
      end
      S_ROT: begin
        if (!z_r[ANG_W-1]) begin
          cx_nxt = cx_r - sy;
          cy_nxt = cy_r + sx;
          z_nxt  = z_r - atan_v;
        end else begin
          cx_nxt = cx_r + sy;
          cy_nxt = cy_r - sx;
          z_nxt  = z_r + atan_v;
        end
        cnt_nxt = CNT_W'(cnt_r + 1'b1);
        if (cnt_r == CNT_W'(ROT_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        // The rotated side component moves x, the rotated forward component moves y.
        if (!cnt_r[0]) begin
          acc_nxt = prod[ACC_W-1:0];
        end else if (cnt_r[1]) begin
          inc_y_nxt = inc;
        end else begin
          inc_x_nxt = inc;
        end
        cnt_nxt = CNT_W'(cnt_r + 1'b1);
        if (cnt_r == CNT_W'(3)) begin
          cnt_nxt   = '0;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        pos_x_nxt = POS_W'(sum_x);
        pos_y_nxt = POS_W'(sum_y);
        if (sum_x > SUM_MAX) begin
          pos_x_nxt = POS_W'(SUM_MAX);
          ovf_nxt   = 1'b1;
        end else if (sum_x < SUM_MIN) begin
          pos_x_nxt = POS_W'(SUM_MIN);
          ovf_nxt   = 1'b1;
        end
        if (sum_y > SUM_MAX) begin
          pos_y_nxt = POS_W'(SUM_MAX);
          ovf_nxt   = 1'b1;
        end else if (sum_y < SUM_MIN) begin
          pos_y_nxt = POS_W'(SUM_MIN);
          ovf_nxt   = 1'b1;
        end
        head_nxt  = prev_h_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = pos_x_r;
          out_y_nxt     = pos_y_r;
          out_h_nxt     = head_r;
          out_ovf_nxt   = ovf_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_we) begin
      case (cfg_index)
        CFG_TILES:     tiles_nxt = cfg_wdata;
        CFG_START_X:   pos_x_nxt = $signed(cfg_wdata);
        CFG_START_Y:   pos_y_nxt = $signed(cfg_wdata);
        CFG_START_HDG: head_nxt  = $signed(cfg_wdata);
        default:       tiles_nxt = tiles_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      primed_r    <= 1'b0;
      prev_f_r    <= '0;
      prev_s_r    <= '0;
      prev_h_r    <= '0;
      tiles_r     <= TILES_RESET;
      pos_x_r     <= START_X_RESET;
      pos_y_r     <= START_Y_RESET;
      head_r      <= START_HDG_RESET;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      primed_r    <= primed_nxt;
      prev_f_r    <= prev_f_nxt;
      prev_s_r    <= prev_s_nxt;
      prev_h_r    <= prev_h_nxt;
      tiles_r     <= tiles_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      head_r      <= head_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_f_r     <= d_f_nxt;
    d_s_r     <= d_s_nxt;
    zacc_r    <= zacc_nxt;
    z_r       <= z_nxt;
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    acc_r     <= acc_nxt;
    inc_x_r   <= inc_x_nxt;
    inc_y_r   <= inc_y_nxt;
    out_x_r   <= out_x_nxt;
    out_y_r   <= out_y_nxt;
    out_h_r   <= out_h_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

endmodule

`default_nettype wire

### rtl/core/twodo_checker.sv
// Port-level assertions for tracking_wheel_odometry, attached to the top level by a bind.
// Depends on twodo_pkg for widths.
`default_nettype none

module twodo_checker import twodo_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [POS_W-1:0] out_pose_x,
  input logic signed [POS_W-1:0] out_pose_y,
  input logic                    out_overflowed
);

  localparam logic signed [POS_W-1:0] POSE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [POS_W-1:0] POSE_MIN = 32'sh8000_0000;

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its x and y pose.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && !out_ready |=> $stable(out_pose_x) && $stable(out_pose_y))
    else $error("stalled result pose changed");

  // Ready is low in the cycle after every accepted sample.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && in_ready |=> !in_ready)
    else $error("sample taken back to back");

  // An overflow flag only comes with a pose component pinned at a limit.
  a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflowed |->
      (out_pose_x == POSE_MAX) || (out_pose_x == POSE_MIN) ||
      (out_pose_y == POSE_MAX) || (out_pose_y == POSE_MIN))
    else $error("overflow flagged without a saturated pose");

endmodule

bind tracking_wheel_odometry twodo_checker u_twodo_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_pose_x     (out_ch.pose_x),
  .out_pose_y     (out_ch.pose_y),
  .out_overflowed (out_ch.overflowed)
);

`default_nettype wire

### test/tracking_wheel_odometry_tb.sv
// Self-checking testbench for tracking_wheel_odometry: sends wheel and heading samples with
// random gaps and result stalls, predicts every pose update and checks each result beat.
// Depends on twodo_pkg and the stream interfaces in twodo_if.sv.
`timescale 1ns / 100ps

module tracking_wheel_odometry_tb;
  import twodo_pkg::*;

  localparam longint LIMIT_CYCLES  = 1000000;
  localparam int     SETTLE_CYCLES = 40;
  localparam int     MAX_WAIT      = 11;
  localparam int     PHASES        = 10;
  localparam int     PHASE_SAMPLES = 143;

  localparam longint COMP_GAIN = 652032874;
  localparam longint TURN      = 360 * 131072;
  localparam int     ROTATIONS = (CORDIC_STEPS < 30) ? CORDIC_STEPS : 30;
  localparam longint POSE_MAX  = 64'sd2147483647;
  localparam longint POSE_MIN  = -64'sd2147483648;

  // One revolution and one degree in Q16.16.
  localparam int REV = 65536;
  localparam int DEG = 65536;
  localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFFFFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 32'sh80000000;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] heading;
    logic                    ovf;
  } pose_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  twodo_in_if  in_ch ();
  twodo_out_if out_ch ();

  tracking_wheel_odometry i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Predicted block state.
  logic [POS_W-1:0] tiles_q;
  bit               primed_q;
  longint           last_fwd_q, last_side_q, last_hdg_q;
  longint           pos_x_q, pos_y_q, hdg_q;

  pose_t pending_poses[$];

  // Last values sent, so that smooth motion continues from them.
  logic signed [POS_W-1:0] last_fwd, last_side, last_hdg;

  bit     back_to_back;
  int     errors;
  int     samples_sent;
  int     results_seen;
  int     saturations;
  int     reg_writes;
  longint cycle_count;

  function automatic longint arc_step(int i);
    case (i)
      0:  return 5898240;
      1:  return 3481934;
      2:  return 1839759;
      3:  return 933890;
      4:  return 468757;
      5:  return 234607;
      6:  return 117332;
      7:  return 58670;
      8:  return 29335;
      9:  return 14668;
      10: return 7334;
      11: return 3667;
      12: return 1833;
      13: return 917;
      14: return 458;
      15: return 229;
      16: return 115;
      17: return 57;
      18: return 29;
      19: return 14;
      20: return 7;
      21: return 4;
      22: return 2;
      23: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic void reset_model();
    tiles_q     = TILES_RESET;
    primed_q    = 1'b0;
    last_fwd_q  = 0;
    last_side_q = 0;
    last_hdg_q  = 0;
    pos_x_q     = 0;
    pos_y_q     = 0;
    hdg_q       = 0;
  endfunction

  // Rounded scale by tiles_per_rev on the magnitude, split so the products stay in 64 bits.
  function automatic longint scale_to_tiles(longint v);
    longint unsigned mag, hi, lo, r;
    mag = (v < 0) ? -v : v;
    hi  = mag >> 16;
    lo  = mag & 64'hFFFF;
    r   = (hi * tiles_q + 64'd524288 + ((lo * tiles_q) >> 16)) >> 20;
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clamp_pose(longint s);
    if (s > POSE_MAX) return POSE_MAX;
    if (s < POSE_MIN) return POSE_MIN;
    return s;
  endfunction

  function automatic pose_t advance_pose(logic signed [POS_W-1:0] fwd,
                                         logic signed [POS_W-1:0] side,
                                         logic signed [POS_W-1:0] hdg);
    longint cx, cy, z, sx, sy, sum_x, sum_y;
    int     i;
    pose_t  p;
    p.ovf = 1'b0;
    if (primed_q) begin
      cx = ((longint'(fwd) - last_fwd_q) * COMP_GAIN) >>> 22;
      cy = ((longint'(side) - last_side_q) * COMP_GAIN) >>> 22;
      // Midpoint heading in 2^-17 degree, brought into [-180, 180) and then folded
      // into [-90, 90] by negating the vector.
      z = (last_hdg_q + longint'(hdg)) % TURN;
      if (z < 0) z += TURN;
      if (z >= TURN / 2) z -= TURN;
      if (z > TURN / 4) begin
        cx = -cx;
        cy = -cy;
        z -= TURN / 2;
      end else if (z < -(TURN / 4)) begin
        cx = -cx;
        cy = -cy;
        z += TURN / 2;
      end
      for (i = 0; i < ROTATIONS; i++) begin
        sx = cx >>> i;
        sy = cy >>> i;
        if (z >= 0) begin
          cx -= sy;
          cy += sx;
          z  -= arc_step(i);
        end else begin
          cx += sy;
          cy -= sx;
          z  += arc_step(i);
        end
      end
      // The rotated side component moves x, the rotated forward component moves y.
      sum_x   = pos_x_q + scale_to_tiles(cy);
      sum_y   = pos_y_q + scale_to_tiles(cx);
      pos_x_q = clamp_pose(sum_x);
      pos_y_q = clamp_pose(sum_y);
      p.ovf   = (pos_x_q != sum_x) || (pos_y_q != sum_y);
      hdg_q   = hdg;
    end
    last_fwd_q  = fwd;
    last_side_q = side;
    last_hdg_q  = hdg;
    primed_q    = 1'b1;
    p.x       = pos_x_q[POS_W-1:0];
    p.y       = pos_y_q[POS_W-1:0];
    p.heading = hdg_q[POS_W-1:0];
    return p;
  endfunction

  task automatic send_sample(input logic signed [POS_W-1:0] fwd,
                             input logic signed [POS_W-1:0] side,
                             input logic signed [POS_W-1:0] hdg);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, MAX_WAIT);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.forward_wheel_pos <= fwd;
    in_ch.side_wheel_pos    <= side;
    in_ch.sensor_heading    <= hdg;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_poses.push_back(advance_pose(fwd, side, hdg));
    samples_sent++;
    last_fwd  = fwd;
    last_side = side;
    last_hdg  = hdg;
  endtask

  // Drops valid, lets every pending pose drain and gives the datapath time to go idle.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_TILES:     tiles_q = val;
      CFG_START_X:   pos_x_q = longint'(signed'(val));
      CFG_START_Y:   pos_y_q = longint'(signed'(val));
      CFG_START_HDG: hdg_q   = longint'(signed'(val));
      default:       ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [POS_W-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0:       return POS_MAX;
      1:       return POS_MIN;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_tiles();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return TILES_RESET;
      3:       return $urandom_range(0, 32'h10000000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_sample();
    logic signed [POS_W-1:0] f, s, h;
    int kind, span, hspan;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      // Smooth motion: wheel steps and turns of widely varying size.
      span  = 1 << $urandom_range(4, 20);
      hspan = 1 << $urandom_range(8, 23);
      f = last_fwd + $urandom_range(0, 2 * span) - span;
      s = last_side + $urandom_range(0, 2 * span) - span;
      h = last_hdg + $urandom_range(0, 2 * hspan) - hspan;
    end else if (kind < 85) begin
      f = $urandom;
      s = $urandom;
      h = $urandom;
    end else begin
      // Jumps to extreme positions and headings on multiples of 45 degrees.
      f = pick_extreme();
      s = pick_extreme();
      h = $urandom_range(0, 16) * 45 * DEG - 360 * DEG;
    end
    send_sample(f, s, h);
  endtask

  task automatic compare_field(input string name, input logic [POS_W-1:0] want,
                               input logic [POS_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  initial begin : result_checker
    pose_t want;
    int    stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = back_to_back ? 0 : $urandom_range(0, MAX_WAIT);
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      if (pending_poses.size() == 0) begin
        errors++;
        $display("%0t: pose beat with no sample pending: x %h y %h heading %h ovf %b",
                 $time, out_ch.pose_x, out_ch.pose_y, out_ch.pose_heading, out_ch.overflowed);
      end else begin
        want = pending_poses.pop_front();
        results_seen++;
        if (want.ovf) saturations++;
        compare_field("pose_x", want.x, out_ch.pose_x);
        compare_field("pose_y", want.y, out_ch.pose_y);
        compare_field("pose_heading", want.heading, out_ch.pose_heading);
        compare_field("overflowed", POS_W'(want.ovf), POS_W'(out_ch.overflowed));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: run exceeded %0d cycles, %0d poses still pending",
               $time, LIMIT_CYCLES, pending_poses.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // The start registers are loaded before the first sample, so the priming result shows
  // the start heading; the next samples move at the default scale.
  task automatic test_priming();
    write_reg(CFG_START_X, 32'sd3 * REV);
    write_reg(CFG_START_Y, -32'sd2 * REV);
    write_reg(CFG_START_HDG, 32'sd30 * DEG);
    send_sample(5 * REV, -3 * REV, 30 * DEG);
    send_sample(6 * REV, -3 * REV, 30 * DEG);
    send_sample(6 * REV, -1 * REV, -45 * DEG);
  endtask

  task automatic test_field_extremes();
    send_sample(POS_MAX, POS_MAX, '0);
    send_sample(POS_MIN, POS_MIN, '0);
    send_sample(POS_MAX, POS_MIN, '0);
    send_sample('0, '0, POS_MAX);
    send_sample('0, '0, POS_MIN);
    send_sample(POS_MIN, POS_MAX, POS_MIN);
  endtask

  // Heading pairs land on the quarter and half turn bounds, just past the quarter bounds, and on wraps.
  task automatic test_heading_folds();
    wait_idle();
    write_reg(CFG_START_X, '0);
    write_reg(CFG_START_Y, '0);
    send_sample(0, 0, 90 * DEG);
    send_sample(REV, REV, 90 * DEG);
    send_sample(2 * REV, REV, 90 * DEG + 1);
    send_sample(3 * REV, 2 * REV, 180 * DEG);
    send_sample(3 * REV, 3 * REV, 180 * DEG);
    send_sample(4 * REV, 3 * REV, -180 * DEG);
    send_sample(5 * REV, 2 * REV, -180 * DEG);
    send_sample(5 * REV, REV, -90 * DEG);
    send_sample(6 * REV, 0, -90 * DEG);
    send_sample(7 * REV, -REV, -90 * DEG - 1);
    send_sample(7 * REV, -2 * REV, 270 * DEG);
  endtask

  task automatic test_saturation();
    wait_idle();
    write_reg(CFG_TILES, '1);
    write_reg(CFG_START_X, 32'sh7FFF0000);
    write_reg(CFG_START_Y, 32'sh80010000);
    send_sample(last_fwd, last_side, 0);
    send_sample(last_fwd + 64 * REV, last_side + 64 * REV, 0);
    send_sample(last_fwd - 64 * REV, last_side - 64 * REV, 0);
  endtask

  // A zero scale leaves the reloaded pose alone; the stored wheel values survive the writes.
  task automatic test_start_reload();
    wait_idle();
    write_reg(CFG_TILES, '0);
    write_reg(CFG_START_X, $urandom);
    write_reg(CFG_START_Y, $urandom);
    write_reg(CFG_START_HDG, -32'sd45 * DEG);
    send_sample(last_fwd + REV, last_side + REV, 10 * DEG);
    wait_idle();
    write_reg(CFG_TILES, TILES_RESET);
    send_sample(last_fwd + 3 * REV, last_side - REV, 20 * DEG);
  endtask

  task automatic test_random_phases();
    int phase, n;
    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      write_reg(CFG_TILES, pick_tiles());
      if ($urandom_range(0, 1)) write_reg(CFG_START_X, pick_extreme());
      if ($urandom_range(0, 1)) write_reg(CFG_START_Y, pick_extreme());
      if ($urandom_range(0, 1)) write_reg(CFG_START_HDG, $urandom);
      back_to_back = (phase % 4 == 3);
      for (n = 0; n < PHASE_SAMPLES; n++) send_random_sample();
      back_to_back = 1'b0;
    end
  endtask

  initial begin
    rst_n                   = 1'b0;
    in_ch.valid             = 1'b0;
    in_ch.forward_wheel_pos = '0;
    in_ch.side_wheel_pos    = '0;
    in_ch.sensor_heading    = '0;
    out_ch.ready            = 1'b0;
    cfg_we                  = 1'b0;
    cfg_index               = CFG_TILES;
    cfg_wdata               = '0;
    last_fwd                = '0;
    last_side               = '0;
    last_hdg                = '0;
    back_to_back            = 1'b0;
    errors                  = 0;
    samples_sent            = 0;
    results_seen            = 0;
    saturations             = 0;
    reg_writes              = 0;
    cycle_count             = 0;
    reset_model();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_priming();
    test_field_extremes();
    test_heading_folds();
    test_saturation();
    test_start_reload();
    test_random_phases();
    wait_idle();

    $display("Sent %0d samples over %0d register writes; checked %0d poses, %0d saturated.",
             samples_sent, reg_writes, results_seen, saturations);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
